/* hw/rtl/assert_macros.svh */
// assertion helpers for the rtl, sampled on clk_i and disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// expression must never be true out of reset
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");

`endif

/* hw/rtl/abfs_pkg.sv */
// ---------------------------------------------------------------------------
// abfs_pkg
// types and constants of the adjacency matrix graph search engine
// ---------------------------------------------------------------------------
package abfs_pkg;

  localparam int unsigned VertexCount = 16;
  localparam int unsigned MaxResults  = 16;
  localparam int unsigned SlotW       = $clog2(VertexCount);
  localparam int unsigned CountW      = $clog2(VertexCount + 1);
  localparam int unsigned LabelW      = 16;

  typedef enum logic [1:0] {
    FUNC_VERTEX = 2'd0,
    FUNC_EDGE   = 2'd1,
    FUNC_SEARCH = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_VISIT     = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]               func;
    logic signed [LabelW-1:0] label_a;
    logic signed [LabelW-1:0] label_b;
    logic signed [LabelW-1:0] distance;
    logic [3:0]               start_index;
  } req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [LabelW-1:0] vertex_label;
    logic                     last;
  } rsp_t;

endpackage

/* hw/rtl/adjacency_matrix_bfs_engine_unit.sv */
// ---------------------------------------------------------------------------
// adjacency_matrix_bfs_engine_unit
// directed graph engine: vertex table, adjacency matrix and breadth-first search
// ---------------------------------------------------------------------------
// one request enters on in_i when in_valid_i is high and in_stall_o low;
// results leave on out_o when out_valid_o is high and out_stall_i low.
// in_stall_o stays high from acceptance until the last result of the request
// has been loaded into the output register.
// a single label comparator is stepped over the vertex slots, one per cycle.
// insert vertex: one result, ok or full.
// insert edge: one result after at most two label scans.
// search: per visited vertex one row scan over the count vertex slots;
// results come in queue order,
// the last one flagged, at most 16 results.
// unused function code: one ok result.
// reset clears the vertex table, the vertex count and the whole matrix at
// once; a request can be accepted in the first cycle after reset.
// a stalled receiver holds the output register; the sequencer waits with
// the next result until the register is free.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adjacency_matrix_bfs_engine_unit import abfs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t in_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  output rsp_t out_o,
  output logic out_valid_o,
  input  logic out_stall_i
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_FIND_A = 6'b000010,
    ST_FIND_B = 6'b000100,
    ST_RESP   = 6'b001000,
    ST_POP    = 6'b010000,
    ST_SCAN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // only the presence of an edge is observable, so one bit per matrix entry
  logic [VertexCount-1:0]   adj_q [VertexCount];
  logic signed [LabelW-1:0] labels_q [VertexCount];
  logic [SlotW-1:0]         queue_q [VertexCount];

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] scan_q, scan_d;
  logic [CountW-1:0] head_q, head_d;
  logic [CountW-1:0] tail_q, tail_d;
  logic [VertexCount-1:0] seen_q, seen_d;
  logic [SlotW-1:0] v_q, v_d;
  logic [SlotW-1:0] slot_a_q, slot_a_d;
  logic [1:0] status_q, status_d;
  req_t req_q, req_d;

  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;

  logic lab_we;
  logic [SlotW-1:0] lab_waddr;
  logic adj_we;
  logic q_we;
  logic [SlotW-1:0] q_waddr, q_wdata;

  logic can_emit, scan_end, cmp_hit, emit_last;
  logic bfs_active;
  logic signed [LabelW-1:0] cmp_target;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign scan_end   = (scan_q >= count_q);
  assign cmp_target = (state_q == ST_FIND_B) ? req_q.label_b : req_q.label_a;
  assign cmp_hit    = (labels_q[scan_q[SlotW-1:0]] == cmp_target);
  assign emit_last  = (head_q == tail_q) || (head_q == CountW'(MaxResults));
  assign bfs_active = (state_q == ST_POP) || (state_q == ST_SCAN);

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    scan_d     = scan_q;
    head_d     = head_q;
    tail_d     = tail_q;
    seen_d     = seen_q;
    v_d        = v_q;
    slot_a_d   = slot_a_q;
    status_d   = status_q;
    req_d      = req_q;
    out_d      = out_q;
    lab_we     = 1'b0;
    lab_waddr  = count_q[SlotW-1:0];
    adj_we     = 1'b0;
    q_we       = 1'b0;
    q_waddr    = tail_q[SlotW-1:0];
    q_wdata    = scan_q[SlotW-1:0];
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_i;
          case (in_i.func)
            FUNC_VERTEX: begin
              if (count_q < CountW'(VertexCount)) begin
                lab_we   = 1'b1;
                count_d  = count_q + 1'b1;
                status_d = STATUS_OK;
              end else begin
                status_d = STATUS_FULL;
              end
              state_d = ST_RESP;
            end
            FUNC_EDGE: begin
              scan_d  = '0;
              state_d = ST_FIND_A;
            end
            FUNC_SEARCH: begin
              q_we    = 1'b1;
              q_waddr = '0;
              q_wdata = in_i.start_index[SlotW-1:0];
              seen_d  = VertexCount'(1) << in_i.start_index[SlotW-1:0];
              head_d  = '0;
              tail_d  = CountW'(1);
              state_d = ST_POP;
            end
            default: begin
              status_d = STATUS_OK;
              state_d  = ST_RESP;
            end
          endcase
        end
      end
      ST_FIND_A: begin
        if (scan_end) begin
          status_d = STATUS_NOT_FOUND;
          state_d  = ST_RESP;
        end else if (cmp_hit) begin
          slot_a_d = scan_q[SlotW-1:0];
          scan_d   = '0;
          state_d  = ST_FIND_B;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_FIND_B: begin
        if (scan_end) begin
          status_d = STATUS_NOT_FOUND;
          state_d  = ST_RESP;
        end else if (cmp_hit) begin
          adj_we   = 1'b1;
          status_d = STATUS_OK;
          state_d  = ST_RESP;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (can_emit) begin
          out_d.status       = status_q;
          out_d.vertex_label = '0;
          out_d.last         = 1'b1;
          out_valid_d        = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_POP: begin
        v_d     = queue_q[head_q[SlotW-1:0]];
        head_d  = head_q + 1'b1;
        scan_d  = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!scan_end) begin
          if (adj_q[v_q][scan_q[SlotW-1:0]] && !seen_q[scan_q[SlotW-1:0]] &&
              (tail_q < CountW'(VertexCount))) begin
            q_we                          = 1'b1;
            seen_d[scan_q[SlotW-1:0]]     = 1'b1;
            tail_d                        = tail_q + 1'b1;
          end
          scan_d = scan_q + 1'b1;
        end else if (can_emit) begin
          out_d.status       = STATUS_VISIT;
          out_d.vertex_label = labels_q[v_q];
          out_d.last         = emit_last;
          out_valid_d        = 1'b1;
          state_d            = emit_last ? ST_IDLE : ST_POP;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      scan_q       <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      seen_q       <= '0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < VertexCount; i++) begin
        labels_q[i] <= '0;
        adj_q[i]    <= '0;
      end
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      seen_q       <= seen_d;
      out_valid_q  <= out_valid_d;
      if (lab_we) begin
        labels_q[lab_waddr] <= in_i.label_a;
      end
      if (adj_we) begin
        adj_q[slot_a_q][scan_q[SlotW-1:0]] <= (req_q.distance != '0);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q      <= v_d;
    slot_a_q <= slot_a_d;
    status_q <= status_d;
    req_q    <= req_d;
    out_q    <= out_d;
    if (q_we) begin
      queue_q[q_waddr] <= q_wdata;
    end
  end

  `ASSERT_CLK(a_count_bound, count_q <= CountW'(VertexCount))
  `ASSERT_CLK(a_head_tail, bfs_active |-> (head_q <= tail_q))
  `ASSERT_CLK(a_busy_after_accept, (in_valid_i && !in_stall_o) |=> in_stall_o)
  `ASSERT_CLK(a_seen_matches_queue, bfs_active |-> (CountW'($countones(seen_q)) == tail_q))
  `ASSERT_NEVER(a_emit_lost, $past(out_valid_q && out_stall_i) && !(out_valid_q && $stable(out_q)))

endmodule
